// ===== hw/rtl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;
    localparam int ADDR_W = 12;
    localparam int SIZE_W = 13;
    localparam int LIMIT_W = 5;
    localparam int BYTES_W = 16;
    localparam int ARENA_GRANULES = 4096;
    localparam int PAGE_SHIFT = 8;
    localparam int GRAN_SHIFT = 4;
    localparam logic [SIZE_W-1:0] ARENA_SZ = SIZE_W'(ARENA_GRANULES);
    localparam logic [SIZE_W-1:0] HDR_GRANULES = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] MIN_SPLIT = SIZE_W'(3);
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_OOM = 1'b1;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] prev;
        logic [SIZE_W-1:0] size;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_entry            wdata;
    } t_mem_req;
endpackage

// ===== hw/rtl/ffha_ram.sv =====
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ffha_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// Sequencer that walks, splits, grows and merges blocks held in the header memory.
`timescale 1ns / 1ps
module ffha_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ffha_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [ffha_pkg::BYTES_W-1:0]  i_request_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0]   i_free_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ffha_pkg::ADDR_W-1:0]   o_block_address,
    output logic                          o_status,
    output ffha_pkg::t_mem_req            o_mem_req,
    input  ffha_pkg::t_entry              i_mem_rdata
);
    typedef enum logic [4:0] {
        S_IDLE, S_FR_RD, S_F_CHK, S_F_RD, S_C_P2, S_C_NX,
        S_G_START, S_G_LS, S_G_CHK,
        S_R_START, S_R_NRD, S_R_NCHK, S_R_NCLR, S_R_PRV, S_R_PCHK, S_R_PCLR,
        S_R_END, S_R_NUP, S_DONE
    } t_state;

    localparam int SW = ffha_pkg::SIZE_W;
    localparam int AW = ffha_pkg::ADDR_W;

    t_state r_state, n_state;
    logic [SW-1:0] r_heap_end, n_heap_end;
    logic [AW-1:0] r_last, n_last;
    logic r_last_v, n_last_v;
    logic [ffha_pkg::LIMIT_W-1:0] r_limit, n_limit;
    logic r_out_valid, n_out_valid;
    logic [AW-1:0] r_out_addr, n_out_addr;
    logic r_out_status, n_out_status;
    logic [AW-1:0] r_res_addr, n_res_addr;
    logic r_res_status, n_res_status;
    logic [SW-1:0] r_need, n_need;
    logic [SW-1:0] r_gneed, n_gneed;
    logic [SW-1:0] r_ls, n_ls;
    logic [SW-1:0] r_p, n_p;
    logic [SW-1:0] r_p2, n_p2;
    logic [SW-1:0] r_cur, n_cur;
    logic [SW-1:0] r_cs, n_cs;
    logic [SW-1:0] r_cp, n_cp;
    logic [SW-1:0] r_nxt, n_nxt;
    logic [SW-1:0] r_prv, n_prv;
    logic r_grow, n_grow;
    logic r_nused, n_nused;

    logic [ffha_pkg::BYTES_W-1:0] w_bytes;
    logic [ffha_pkg::BYTES_W:0] w_bsum;
    logic [SW-1:0] w_hdr, w_lim, w_lim_raw, w_inc, w_gsum, w_q, w_sum;

    always_comb begin
        w_bytes = (i_request_bytes == '0) ? ffha_pkg::BYTES_W'(1) : i_request_bytes;
        w_bsum = {1'b0, w_bytes} + (ffha_pkg::BYTES_W + 1)'(15);
        w_hdr = {1'b0, i_free_address} - ffha_pkg::HDR_GRANULES;
        w_lim_raw = {r_limit, {ffha_pkg::PAGE_SHIFT{1'b0}}};
        w_lim = (w_lim_raw > ffha_pkg::ARENA_SZ) ? ffha_pkg::ARENA_SZ : w_lim_raw;
        w_gsum = r_gneed + SW'(255);
        w_inc = {w_gsum[SW-1:ffha_pkg::PAGE_SHIFT], {ffha_pkg::PAGE_SHIFT{1'b0}}};
        w_q = r_p2 + r_cs;
        w_sum = r_cs + i_mem_rdata.size;
    end

    always_comb begin
        n_state = r_state;
        n_heap_end = r_heap_end;
        n_last = r_last;
        n_last_v = r_last_v;
        n_limit = i_cfg_we ? i_cfg_wdata : r_limit;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;
        n_out_addr = r_out_addr;
        n_out_status = r_out_status;
        n_res_addr = r_res_addr;
        n_res_status = r_res_status;
        n_need = r_need;
        n_gneed = r_gneed;
        n_ls = r_ls;
        n_p = r_p;
        n_p2 = r_p2;
        n_cur = r_cur;
        n_cs = r_cs;
        n_cp = r_cp;
        n_nxt = r_nxt;
        n_prv = r_prv;
        n_grow = r_grow;
        n_nused = r_nused;
        o_mem_req = '0;
        o_in_ready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_addr = '0;
                    n_res_status = ffha_pkg::ST_DONE;
                    if (i_operation == ffha_pkg::OP_ALLOC) begin
                        n_need = w_bsum[ffha_pkg::BYTES_W:ffha_pkg::GRAN_SHIFT]
                                 + ffha_pkg::HDR_GRANULES;
                        n_p = '0;
                        n_state = S_F_CHK;
                    end else if ({1'b0, i_free_address} >= ffha_pkg::HDR_GRANULES
                                 && w_hdr < r_heap_end) begin
                        o_mem_req.addr = w_hdr[AW-1:0];
                        n_cur = w_hdr;
                        n_state = S_FR_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FR_RD: begin
                if (i_mem_rdata.used) begin
                    n_cs = i_mem_rdata.size;
                    n_cp = i_mem_rdata.prev;
                    n_grow = 1'b0;
                    n_state = S_R_START;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_F_CHK: begin
                if (r_p >= r_heap_end) begin
                    n_state = S_G_START;
                end else begin
                    o_mem_req.addr = r_p[AW-1:0];
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                if (i_mem_rdata.size == '0 || i_mem_rdata.size > r_heap_end - r_p) begin
                    n_state = S_G_START;
                end else if (!i_mem_rdata.used && i_mem_rdata.size >= r_need) begin
                    o_mem_req.we = 1'b1;
                    o_mem_req.addr = r_p[AW-1:0];
                    o_mem_req.wdata.used = 1'b1;
                    o_mem_req.wdata.prev = i_mem_rdata.prev;
                    n_res_addr = r_p[AW-1:0] + AW'(ffha_pkg::HDR_GRANULES);
                    if (i_mem_rdata.size - r_need >= ffha_pkg::MIN_SPLIT) begin
                        o_mem_req.wdata.size = r_need;
                        n_p2 = r_p + r_need;
                        n_cs = i_mem_rdata.size - r_need;
                        n_state = S_C_P2;
                    end else begin
                        o_mem_req.wdata.size = i_mem_rdata.size;
                        n_state = S_DONE;
                    end
                end else begin
                    n_p = r_p + i_mem_rdata.size;
                    n_state = S_F_CHK;
                end
            end
            S_C_P2: begin
                o_mem_req.we = 1'b1;
                o_mem_req.addr = r_p2[AW-1:0];
                o_mem_req.wdata.used = 1'b0;
                o_mem_req.wdata.prev = r_need;
                o_mem_req.wdata.size = r_cs;
                if (r_last_v && {1'b0, r_last} == r_p) begin
                    n_last = r_p2[AW-1:0];
                    n_state = S_DONE;
                end else if (r_last_v && {1'b0, r_last} == r_p2) begin
                    n_state = S_DONE;
                end else if (w_q < ffha_pkg::ARENA_SZ) begin
                    n_nxt = w_q;
                    n_state = S_C_NX;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_C_NX: begin
                if (r_nused) begin
                    o_mem_req.we = 1'b1;
                    o_mem_req.addr = r_nxt[AW-1:0];
                    o_mem_req.wdata.used = i_mem_rdata.used;
                    o_mem_req.wdata.prev = r_cs;
                    o_mem_req.wdata.size = i_mem_rdata.size;
                    n_nused = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_mem_req.addr = r_nxt[AW-1:0];
                    n_nused = 1'b1;
                end
            end
            S_G_START: begin
                n_gneed = r_need;
                n_ls = '0;
                if (r_last_v) begin
                    o_mem_req.addr = r_last;
                    n_state = S_G_LS;
                end else begin
                    n_state = S_G_CHK;
                end
            end
            S_G_LS: begin
                n_ls = i_mem_rdata.size;
                if (!i_mem_rdata.used) begin
                    n_gneed = (i_mem_rdata.size >= r_need) ? '0 : r_need - i_mem_rdata.size;
                end
                n_state = S_G_CHK;
            end
            S_G_CHK: begin
                if (w_inc == '0 || r_heap_end >= w_lim || w_inc > w_lim - r_heap_end) begin
                    n_res_addr = '0;
                    n_res_status = ffha_pkg::ST_OOM;
                    n_state = S_DONE;
                end else begin
                    n_cur = r_heap_end;
                    n_cs = w_inc;
                    n_cp = r_last_v ? r_ls : '0;
                    n_heap_end = r_heap_end + w_inc;
                    n_grow = 1'b1;
                    n_state = S_R_START;
                end
            end
            S_R_START: begin
                o_mem_req.we = 1'b1;
                o_mem_req.addr = r_cur[AW-1:0];
                o_mem_req.wdata.used = 1'b0;
                o_mem_req.wdata.prev = r_cp;
                o_mem_req.wdata.size = r_cs;
                n_nxt = r_cur + r_cs;
                n_prv = (r_cp > r_cur) ? r_cur : r_cur - r_cp;
                n_state = S_R_NRD;
            end
            S_R_NRD: begin
                if (r_nxt < r_heap_end) begin
                    o_mem_req.addr = r_nxt[AW-1:0];
                    n_state = S_R_NCHK;
                end else begin
                    n_state = S_R_PRV;
                end
            end
            S_R_NCHK: begin
                if (!i_mem_rdata.used) begin
                    o_mem_req.we = 1'b1;
                    o_mem_req.addr = r_cur[AW-1:0];
                    o_mem_req.wdata.used = 1'b0;
                    o_mem_req.wdata.prev = r_cp;
                    o_mem_req.wdata.size = w_sum;
                    n_cs = w_sum;
                    n_nused = i_mem_rdata.used;
                    n_state = S_R_NCLR;
                end else begin
                    n_state = S_R_PRV;
                end
            end
            S_R_NCLR: begin
                o_mem_req.we = 1'b1;
                o_mem_req.addr = r_nxt[AW-1:0];
                o_mem_req.wdata.used = r_nused;
                n_nused = 1'b0;
                n_nxt = r_cur + r_cs;
                n_state = S_R_PRV;
            end
            S_R_PRV: begin
                if (r_prv != r_cur) begin
                    o_mem_req.addr = r_prv[AW-1:0];
                    n_state = S_R_PCHK;
                end else begin
                    n_state = S_R_END;
                end
            end
            S_R_PCHK: begin
                if (!i_mem_rdata.used) begin
                    o_mem_req.we = 1'b1;
                    o_mem_req.addr = r_prv[AW-1:0];
                    o_mem_req.wdata.used = i_mem_rdata.used;
                    o_mem_req.wdata.prev = i_mem_rdata.prev;
                    o_mem_req.wdata.size = w_sum;
                    n_cs = w_sum;
                    n_state = S_R_PCLR;
                end else begin
                    n_state = S_R_END;
                end
            end
            S_R_PCLR: begin
                o_mem_req.we = 1'b1;
                o_mem_req.addr = r_cur[AW-1:0];
                n_cur = r_prv;
                n_state = S_R_END;
            end
            S_R_END: begin
                if (r_nxt >= r_heap_end) begin
                    n_last = r_cur[AW-1:0];
                    n_last_v = 1'b1;
                    n_p = '0;
                    n_state = r_grow ? S_F_CHK : S_DONE;
                end else begin
                    o_mem_req.addr = r_nxt[AW-1:0];
                    n_state = S_R_NUP;
                end
            end
            S_R_NUP: begin
                if (i_mem_rdata.used) begin
                    o_mem_req.we = 1'b1;
                    o_mem_req.addr = r_nxt[AW-1:0];
                    o_mem_req.wdata.used = i_mem_rdata.used;
                    o_mem_req.wdata.prev = r_cs;
                    o_mem_req.wdata.size = i_mem_rdata.size;
                end
                n_p = '0;
                n_state = r_grow ? S_F_CHK : S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_addr = r_res_addr;
                    n_out_status = r_res_status;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_heap_end <= '0;
            r_last <= '0;
            r_last_v <= 1'b0;
            r_limit <= ffha_pkg::LIMIT_W'(16);
            r_out_valid <= 1'b0;
            r_nused <= 1'b0;
        end else begin
            r_state <= n_state;
            r_heap_end <= n_heap_end;
            r_last <= n_last;
            r_last_v <= n_last_v;
            r_limit <= n_limit;
            r_out_valid <= n_out_valid;
            r_nused <= n_nused;
        end
        r_out_addr <= n_out_addr;
        r_out_status <= n_out_status;
        r_res_addr <= n_res_addr;
        r_res_status <= n_res_status;
        r_need <= n_need;
        r_gneed <= n_gneed;
        r_ls <= n_ls;
        r_p <= n_p;
        r_p2 <= n_p2;
        r_cur <= n_cur;
        r_cs <= n_cs;
        r_cp <= n_cp;
        r_nxt <= n_nxt;
        r_prv <= n_prv;
        r_grow <= n_grow;
    end

    assign o_out_valid = r_out_valid;
    assign o_block_address = r_out_addr;
    assign o_status = r_out_status;

    a_heap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heap_end <= ffha_pkg::ARENA_SZ)
        else $error("heap end beyond arena");

    a_last_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_v |-> ({1'b0, r_last} < r_heap_end))
        else $error("last block outside heap");

    a_grow_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) || $stable(r_heap_end) || $past(r_state) == S_G_CHK)
        else $error("heap end changed outside growth");
endmodule

// ===== hw/rtl/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: sequencer plus header memory.
//
// Usage: an item on the input channel (i_in_valid / o_in_ready) is either an
// allocate of i_request_bytes or a free of the payload granule i_free_address.
// Each item yields exactly one result beat on the output channel
// (o_out_valid / i_out_ready) carrying o_block_address and o_status.
// Items are handled one at a time. An allocate runs a first-fit walk over
// the block headers in the single-port header memory and splits the chosen
// block when enough is left over; reaching the heap end starts a growth of
// the heap and a second walk, or ends the item with a failure. The next item
// is taken from the cycle its result is shown. The heap limit is written
// through i_cfg_we / i_cfg_wdata; the user must do so only while the block
// is idle, as the block itself does not enforce it.
// After reset the heap is empty and the limit is 16 pages; no clearing pass
// runs, so the first item is taken at once. The output register lets the
// next item be taken while a result waits; if the receiver stalls, the
// following result is held in the sequencer until the register frees.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ffha_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [ffha_pkg::BYTES_W-1:0]  i_request_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0]   i_free_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ffha_pkg::ADDR_W-1:0]   o_block_address,
    output logic                          o_status
);
    ffha_pkg::t_mem_req w_req;
    ffha_pkg::t_entry w_rdata;

    ffha_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_operation(i_operation),
        .i_request_bytes(i_request_bytes),
        .i_free_address(i_free_address),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_block_address(o_block_address),
        .o_status(o_status),
        .o_mem_req(w_req),
        .i_mem_rdata(w_rdata)
    );

    ffha_ram #(
        .WIDTH(ffha_pkg::ENTRY_W),
        .DEPTH(ffha_pkg::ARENA_GRANULES)
    ) u_ram (
        .i_clk(i_clk),
        .i_we(w_req.we),
        .i_addr(w_req.addr),
        .i_wdata(w_req.wdata),
        .o_rdata(w_rdata)
    );
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the first-fit heap allocator top level.
`timescale 1ns / 1ps
module tb_top;
    localparam int STALL_LIMIT = 40000;
    localparam int ARENA = 4096;
    localparam int PAGE = 256;
    localparam int HDR = 2;

    typedef struct {
        logic                         op;
        logic [ffha_pkg::BYTES_W-1:0] bytes;
        logic [ffha_pkg::ADDR_W-1:0]  faddr;
    } t_request;

    typedef struct {
        logic [ffha_pkg::ADDR_W-1:0] addr;
        logic                        st;
    } t_grant;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [ffha_pkg::LIMIT_W-1:0] i_cfg_wdata = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_operation = ffha_pkg::OP_ALLOC;
    logic [ffha_pkg::BYTES_W-1:0] i_request_bytes = '0;
    logic [ffha_pkg::ADDR_W-1:0]  i_free_address = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [ffha_pkg::ADDR_W-1:0]  o_block_address;
    logic                         o_status;

    first_fit_heap_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation), .i_request_bytes(i_request_bytes),
        .i_free_address(i_free_address),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_block_address(o_block_address), .o_status(o_status)
    );

    t_request    pending_reqs[$];
    t_grant      expected_grants[$];
    logic [11:0] live_blocks[$];
    int          send_idle = 31;
    int          recv_idle = 83;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    int unsigned blk_size[ARENA];
    int unsigned blk_prev[ARENA];
    bit          blk_used[ARENA];
    bit          used_known[ARENA];
    int unsigned heap_top = 0;
    int unsigned tail_addr = 0;
    bit          tail_valid = 1'b0;
    int unsigned limit_pages = 16;

    function automatic int unsigned get_size(int unsigned a);
        return a < ARENA ? blk_size[a] : 0;
    endfunction
    function automatic int unsigned get_prev(int unsigned a);
        return a < ARENA ? blk_prev[a] : 0;
    endfunction
    function automatic bit get_used(int unsigned a);
        return a < ARENA ? blk_used[a] : 1'b0;
    endfunction
    function automatic void set_size(int unsigned a, int unsigned v);
        if (a < ARENA) blk_size[a] = v;
    endfunction
    function automatic void set_prev(int unsigned a, int unsigned v);
        if (a < ARENA) blk_prev[a] = v;
    endfunction
    function automatic void set_used(int unsigned a, bit v);
        if (a < ARENA) begin
            blk_used[a] = v;
            used_known[a] = 1'b1;
        end
    endfunction

    function automatic void release_block(int unsigned cur);
        int unsigned nxt, prv;
        nxt = cur + get_size(cur);
        prv = cur - get_prev(cur);
        if (get_prev(cur) > cur) prv = cur;
        set_used(cur, 1'b0);
        if (nxt < heap_top && !get_used(nxt)) begin
            set_size(cur, get_size(cur) + get_size(nxt));
            set_size(nxt, 0);
            set_prev(nxt, 0);
            nxt = cur + get_size(cur);
        end
        if (prv != cur && !get_used(prv)) begin
            set_size(prv, get_size(prv) + get_size(cur));
            set_size(cur, 0);
            set_prev(cur, 0);
            cur = prv;
        end
        if (nxt >= heap_top) begin
            tail_addr = cur;
            tail_valid = 1'b1;
        end else if (get_used(nxt)) begin
            set_prev(nxt, get_size(cur));
        end
    endfunction

    function automatic void divide_block(int unsigned p, int unsigned need);
        int unsigned total, p2, rest;
        total = get_size(p);
        if (total - need >= HDR + 1) begin
            p2 = p + need;
            rest = total - need;
            set_size(p, need);
            set_prev(p2, need);
            set_size(p2, rest);
            set_used(p2, 1'b0);
            if (tail_valid && tail_addr == p) tail_addr = p2;
            if (!(tail_valid && tail_addr == p2)) set_prev(p2 + rest, rest);
        end
    endfunction

    function automatic int unsigned scan_fit(int unsigned need);
        int unsigned p, steps, sz;
        p = 0;
        steps = 0;
        while (p < heap_top && steps <= ARENA) begin
            sz = get_size(p);
            if (sz == 0 || sz > heap_top - p) return 0;
            if (!get_used(p) && sz >= need) begin
                divide_block(p, need);
                set_used(p, 1'b1);
                return p + HDR;
            end
            p += sz;
            steps++;
        end
        return 0;
    endfunction

    function automatic bit grow_heap(int unsigned need);
        int unsigned lim, inc, blk, ls;
        lim = limit_pages * PAGE;
        if (lim > ARENA) lim = ARENA;
        if (tail_valid && !get_used(tail_addr)) begin
            ls = get_size(tail_addr);
            need = ls >= need ? 0 : need - ls;
        end
        inc = ((need + PAGE - 1) / PAGE) * PAGE;
        if (inc == 0 || heap_top >= lim || inc > lim - heap_top) return 1'b0;
        blk = heap_top;
        set_size(blk, inc);
        set_used(blk, 1'b1);
        set_prev(blk, tail_valid ? get_size(tail_addr) : 0);
        heap_top = blk + inc;
        release_block(blk);
        return 1'b1;
    endfunction

    function automatic void queue_request(logic op, logic [15:0] bytes, logic [11:0] faddr);
        t_request    req;
        t_grant      g;
        int unsigned need, got, b, hdr;
        req.op = op;
        req.bytes = bytes;
        req.faddr = faddr;
        g.addr = '0;
        g.st = ffha_pkg::ST_DONE;
        if (op == ffha_pkg::OP_ALLOC) begin
            b = (bytes == 0) ? 1 : bytes;
            need = (b + 15) / 16 + HDR;
            forever begin
                got = scan_fit(need);
                if (got != 0 || !grow_heap(need)) break;
            end
            if (got != 0) begin
                g.addr = got[11:0];
                live_blocks.push_back(got[11:0]);
            end else begin
                g.st = ffha_pkg::ST_OOM;
            end
        end else if (faddr >= HDR) begin
            hdr = faddr - HDR;
            if (hdr < heap_top && get_used(hdr)) release_block(hdr);
            foreach (live_blocks[i]) begin
                if (live_blocks[i] == faddr) begin
                    live_blocks.delete(i);
                    break;
                end
            end
        end
        pending_reqs.push_back(req);
        expected_grants.push_back(g);
    endfunction

    function automatic logic [11:0] pick_free_addr();
        int          r;
        logic [11:0] a;
        int unsigned hdr;
        r = $urandom_range(99);
        if (r < 65 && live_blocks.size() > 0)
            return live_blocks[$urandom_range(live_blocks.size() - 1)];
        if (r < 72) return 12'($urandom_range(1));
        a = 12'($urandom);
        hdr = a - HDR;
        if (a >= HDR && hdr < heap_top && !used_known[hdr])
            a = (live_blocks.size() > 0) ? live_blocks[0] : 12'd0;
        return a;
    endfunction

    function automatic logic [15:0] pick_bytes();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'($urandom_range(160));
        if (r < 92) return 16'($urandom_range(2000));
        return 16'($urandom);
    endfunction

    task automatic queue_random(int count);
        repeat (count) begin
            if ($urandom_range(99) < 55)
                queue_request(ffha_pkg::OP_ALLOC, pick_bytes(), 12'($urandom));
            else
                queue_request(ffha_pkg::OP_FREE, 16'($urandom), pick_free_addr());
        end
    endtask

    task automatic drain_and_set_limit(logic [ffha_pkg::LIMIT_W-1:0] value);
        wait (pending_reqs.size() == 0 && expected_grants.size() == 0);
        repeat (20) @(posedge i_clk);
        i_cfg_wdata <= value;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_pages = value;
        @(posedge i_clk);
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        logic [11:0] a;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drain_and_set_limit(5'd16);
        queue_request(ffha_pkg::OP_ALLOC, 16'd0, 12'd0);
        queue_request(ffha_pkg::OP_ALLOC, 16'd1, 12'hFFF);
        queue_request(ffha_pkg::OP_ALLOC, 16'hFFFF, 12'd0);
        queue_request(ffha_pkg::OP_ALLOC, 16'd16, 12'd0);
        queue_request(ffha_pkg::OP_ALLOC, 16'd17, 12'd0);
        queue_request(ffha_pkg::OP_ALLOC, 16'd48, 12'd0);
        queue_request(ffha_pkg::OP_FREE, 16'd0, 12'd0);
        queue_request(ffha_pkg::OP_FREE, 16'hFFFF, 12'd1);
        queue_request(ffha_pkg::OP_FREE, 16'd0, 12'hFFF);
        a = live_blocks[1];
        queue_request(ffha_pkg::OP_FREE, 16'd0, a);
        queue_request(ffha_pkg::OP_FREE, 16'd0, a);
        queue_request(ffha_pkg::OP_ALLOC, 16'd16, 12'd0);
        queue_request(ffha_pkg::OP_FREE, 16'd0, live_blocks[0]);
        queue_request(ffha_pkg::OP_FREE, 16'd0, live_blocks[0]);
        queue_request(ffha_pkg::OP_ALLOC, 16'd4000, 12'd0);
        queue_request(ffha_pkg::OP_ALLOC, 16'd65000, 12'd0);
        queue_request(ffha_pkg::OP_ALLOC, 16'd30000, 12'd0);
        queue_random(120);
        drain_and_set_limit(5'd1);
        send_idle = 83;
        recv_idle = 31;
        queue_random(130);
        drain_and_set_limit(5'd0);
        send_idle = 0;
        recv_idle = 0;
        queue_random(40);
        drain_and_set_limit(5'd12);
        queue_random(110);
        wait (pending_reqs.size() == 0 && expected_grants.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        bit fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire) void'(pending_reqs.pop_front());
            if (!i_in_valid || fire) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_operation <= pending_reqs[0].op;
                    i_request_bytes <= pending_reqs[0].bytes;
                    i_free_address <= pending_reqs[0].faddr;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant g;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_grants.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: addr=%0d status=%0d",
                                 o_block_address, o_status);
                end else begin
                    g = expected_grants.pop_front();
                    if (o_block_address !== g.addr || o_status !== g.st) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected addr=%0d status=%0d, ",
                                      "got addr=%0d status=%0d"},
                                     g.addr, g.st, o_block_address, o_status);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end
endmodule

// ===== first_fit_heap_allocator_top.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ram.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_top.sv
dv/tb_top.sv
